@@ rtl/fcip_pkg.sv @@
// Shared types and constants for the framed CSV integer parser.
// Used by fcip_field, fcip_outq and framed_csv_integer_parser_top.
package fcip_pkg;

    localparam logic [7:0] START_CHAR_RST = 8'd35;
    localparam logic [7:0] END_CHAR_RST   = 8'd98;
    localparam logic [7:0] SEP_CHAR_RST   = 8'd44;

    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_PLUS  = 8'd43;
    localparam logic [7:0] CH_MINUS = 8'd45;
    localparam logic [7:0] CH_ZERO  = 8'd48;
    localparam logic [7:0] CH_NINE  = 8'd57;

    localparam int VALUE_W = 16;
    localparam int SLOT_W  = 6;

    typedef enum logic [1:0] {
        CFG_START = 2'd0,
        CFG_END   = 2'd1,
        CFG_SEP   = 2'd2
    } cfg_idx_t;

    typedef enum logic [1:0] {
        PH_SKIP   = 2'd0,
        PH_DIGITS = 2'd1,
        PH_DONE   = 2'd2
    } phase_t;

    typedef struct packed {
        logic feed;
        logic clear;
    } field_ctrl_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic [SLOT_W-1:0]         slot;
        logic                      done;
    } result_t;

endpackage

@@ rtl/fcip_field.sv @@
// atoi-style field parser: whitespace skip, optional sign, decimal digits.
// Depends on fcip_pkg for phase_t and field_ctrl_t.
module fcip_field
    import fcip_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  field_ctrl_t               ctrl,
    input  logic [7:0]                rx_byte,
    output logic signed [VALUE_W-1:0] value
);

    phase_t               phase_reg, phase_next;
    logic                 neg_reg, neg_next;
    logic [VALUE_W-1:0]   acc_reg, acc_next;
    logic                 is_digit;
    logic                 is_space;
    logic [VALUE_W-1:0]   acc_step;

    assign is_digit = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
    assign is_space = (rx_byte == CH_SPACE) || ((rx_byte >= CH_TAB) && (rx_byte <= CH_CR));
    assign acc_step = (acc_reg << 3) + (acc_reg << 1)
                      + {{(VALUE_W-8){1'b0}}, rx_byte - CH_ZERO};
    assign value    = neg_reg ? -acc_reg : acc_reg;

    always_comb
    begin
        phase_next = phase_reg;
        neg_next   = neg_reg;
        acc_next   = acc_reg;
        if (ctrl.clear)
        begin
            phase_next = PH_SKIP;
            neg_next   = 1'b0;
            acc_next   = '0;
        end
        else if (ctrl.feed)
        begin
            unique case (phase_reg)
                PH_SKIP:
                begin
                    if (is_space)
                    begin
                        phase_next = PH_SKIP;
                    end
                    else if ((rx_byte == CH_PLUS) || (rx_byte == CH_MINUS))
                    begin
                        neg_next   = (rx_byte == CH_MINUS);
                        phase_next = PH_DIGITS;
                    end
                    else if (is_digit)
                    begin
                        acc_next   = acc_step;
                        phase_next = PH_DIGITS;
                    end
                    else
                    begin
                        phase_next = PH_DONE;
                    end
                end
                PH_DIGITS:
                begin
                    if (is_digit)
                    begin
                        acc_next = acc_step;
                    end
                    else
                    begin
                        phase_next = PH_DONE;
                    end
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_SKIP;
            neg_reg   <= 1'b0;
            acc_reg   <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            neg_reg   <= neg_next;
            acc_reg   <= acc_next;
        end
    end

endmodule

@@ rtl/fcip_outq.sv @@
// Two-entry result queue: output register plus skid slot.
// Depends on fcip_pkg for result_t.
module fcip_outq
    import fcip_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  result_t push_data,
    output logic    full,
    output logic    res_valid,
    input  logic    res_stall,
    output result_t res_data
);

    result_t     slot0_reg;
    result_t     slot1_reg;
    logic [1:0]  count_reg, count_next;
    logic        pop;
    logic [1:0]  wr_pos;

    assign pop       = res_valid && !res_stall;
    assign res_valid = (count_reg != 2'd0);
    assign full      = (count_reg == 2'd2);
    assign res_data  = slot0_reg;
    assign wr_pos    = count_reg - {1'b0, pop};
    assign count_next = count_reg + {1'b0, push} - {1'b0, pop};

    always_ff @(posedge clk)
    begin
        if (push && (wr_pos == 2'd0))
        begin
            slot0_reg <= push_data;
        end
        else if (pop)
        begin
            slot0_reg <= slot1_reg;
        end
        if (push && (wr_pos != 2'd0))
        begin
            slot1_reg <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

endmodule

@@ rtl/framed_csv_integer_parser_top.sv @@
// Framed CSV integer parser, top level: framing, counting and result emit.
// Depends on fcip_pkg, fcip_field and fcip_outq.
//
// Usage:
//   Byte channel rx_valid/rx_stall/rx_byte: one byte per cycle unless rx_stall.
//   Bytes outside a frame are ignored until start_char opens one. Inside a
//   frame each separator_char yields a request on the result channel
//   (field_value, slot_index, frame_done = 0) for the first MAX_VALUES fields;
//   end_char yields a done request carrying the value count (frame_done = 1).
//   Payload beyond PACKET_BYTES per frame is dropped.
//   Results: each result is written into the output queue when its byte is
//   accepted. Throughput: one byte per cycle while rx_stall is low; the sign
//   negation is the only arithmetic between field state and result register.
//   Stall: results sit in a two-entry output queue; rx_stall rises only when
//   both entries hold untaken results, so a single stalled result does not
//   block the byte channel.
//   Config: cfg_valid/cfg_ready write start, end or separator character;
//   cfg_ready is always high. Reset restores '#', 'b', ',' and leaves the
//   block outside a frame with an empty queue.
module framed_csv_integer_parser_top
    import fcip_pkg::*;
#(
    parameter int MAX_VALUES   = 32,
    parameter int PACKET_BYTES = 64
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      rx_valid,
    output logic                      rx_stall,
    input  logic [7:0]                rx_byte,
    output logic                      res_valid,
    input  logic                      res_stall,
    output logic signed [VALUE_W-1:0] field_value,
    output logic [SLOT_W-1:0]         slot_index,
    output logic                      frame_done,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [1:0]                cfg_index,
    input  logic [7:0]                cfg_data
);

    localparam int PC_W = $clog2(PACKET_BYTES + 1);
    localparam logic [PC_W-1:0]   PC_MAX = PC_W'(PACKET_BYTES);
    localparam logic [SLOT_W-1:0] VC_MAX = SLOT_W'(MAX_VALUES);

    logic [7:0]          start_reg, end_reg, sep_reg;
    logic                in_frame_reg, in_frame_next;
    logic [PC_W-1:0]     pc_reg, pc_next;
    logic [SLOT_W-1:0]   vc_reg, vc_next;
    logic                accept;
    logic                push;
    logic                q_full;
    result_t             push_data;
    result_t             res_data;
    field_ctrl_t         fctrl;
    logic signed [VALUE_W-1:0] cur_value;

    assign cfg_ready = 1'b1;
    assign rx_stall  = q_full;
    assign accept    = rx_valid && !rx_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg <= START_CHAR_RST;
            end_reg   <= END_CHAR_RST;
            sep_reg   <= SEP_CHAR_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_START: start_reg <= cfg_data;
                CFG_END:   end_reg   <= cfg_data;
                CFG_SEP:   sep_reg   <= cfg_data;
                default:   start_reg <= start_reg;
            endcase
        end
    end

    always_comb
    begin
        in_frame_next   = in_frame_reg;
        pc_next         = pc_reg;
        vc_next         = vc_reg;
        push            = 1'b0;
        push_data.value = cur_value;
        push_data.slot  = vc_reg;
        push_data.done  = 1'b0;
        fctrl.feed      = 1'b0;
        fctrl.clear     = 1'b0;
        if (accept)
        begin
            if (!in_frame_reg)
            begin
                if (rx_byte == start_reg)
                begin
                    in_frame_next = 1'b1;
                    pc_next       = '0;
                    vc_next       = '0;
                    fctrl.clear   = 1'b1;
                end
            end
            else if (rx_byte == end_reg)
            begin
                in_frame_next   = 1'b0;
                push            = 1'b1;
                push_data.value = '0;
                push_data.done  = 1'b1;
                fctrl.clear     = 1'b1;
            end
            else if (pc_reg < PC_MAX)
            begin
                pc_next = pc_reg + 1'b1;
                if (rx_byte == sep_reg)
                begin
                    fctrl.clear = 1'b1;
                    if (vc_reg < VC_MAX)
                    begin
                        push    = 1'b1;
                        vc_next = vc_reg + 1'b1;
                    end
                end
                else
                begin
                    fctrl.feed = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg <= 1'b0;
            pc_reg       <= '0;
            vc_reg       <= '0;
        end
        else
        begin
            in_frame_reg <= in_frame_next;
            pc_reg       <= pc_next;
            vc_reg       <= vc_next;
        end
    end

    fcip_field u_field (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (fctrl),
        .rx_byte (rx_byte),
        .value   (cur_value)
    );

    fcip_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data)
    );

    assign field_value = res_data.value;
    assign slot_index  = res_data.slot;
    assign frame_done  = res_data.done;

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_full)
        else $error("result pushed into full queue");

    a_vc_bound: assert property (@(posedge clk) disable iff (!rst_n)
        vc_reg <= VC_MAX)
        else $error("value count past limit");

    a_pc_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pc_reg <= PC_MAX)
        else $error("payload count past limit");

    a_done_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (push && push_data.done) |=> !in_frame_reg)
        else $error("frame still open after done marker");

endmodule

@@ test/tb.sv @@
// Testbench for framed_csv_integer_parser_top: random framed byte streams and register
// writes, with random idling on both channels; each result is checked against a predictor.
// Depends on fcip_pkg and the parser RTL.
module tb;
    import fcip_pkg::*;

    localparam int MAX_VALUES   = 32;
    localparam int PACKET_BYTES = 64;
    localparam int CYCLE_LIMIT  = 500000;
    localparam logic [1:0] CFG_UNUSED = 2'd3;

    class parsed_value_board;
        logic [7:0]  start_ch = START_CHAR_RST;
        logic [7:0]  end_ch   = END_CHAR_RST;
        logic [7:0]  sep_ch   = SEP_CHAR_RST;
        bit          in_frame;
        int          payload_cnt;
        int          value_cnt;
        phase_t      phase = PH_SKIP;
        bit          neg;
        logic [15:0] acc;
        result_t     pending_values[$];
        int          frame_bytes;
        int          errors;

        function void clear_field();
            phase = PH_SKIP;
            neg   = 1'b0;
            acc   = '0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [7:0] val);
            case (idx)
                CFG_START: start_ch = val;
                CFG_END:   end_ch   = val;
                CFG_SEP:   sep_ch   = val;
                default:   ;
            endcase
        endfunction

        function void take_byte(logic [7:0] b);
            result_t r;
            if (!in_frame) begin
                if (b == start_ch) begin
                    in_frame    = 1'b1;
                    payload_cnt = 0;
                    value_cnt   = 0;
                    clear_field();
                    frame_bytes++;
                end
                return;
            end
            frame_bytes++;
            if (b == end_ch) begin
                in_frame = 1'b0;
                r.value  = '0;
                r.slot   = SLOT_W'(value_cnt);
                r.done   = 1'b1;
                pending_values.push_back(r);
                clear_field();
                return;
            end
            if (payload_cnt >= PACKET_BYTES)
                return;
            payload_cnt++;
            if (b == sep_ch) begin
                if (value_cnt < MAX_VALUES) begin
                    r.value = neg ? -acc : acc;
                    r.slot  = SLOT_W'(value_cnt);
                    r.done  = 1'b0;
                    pending_values.push_back(r);
                    value_cnt++;
                end
                clear_field();
                return;
            end
            if (phase == PH_SKIP) begin
                if (b == CH_SPACE || (b >= CH_TAB && b <= CH_CR))
                    return;
                phase = PH_DIGITS;
                if (b == CH_PLUS || b == CH_MINUS) begin
                    neg = (b == CH_MINUS);
                    return;
                end
            end
            if (phase == PH_DIGITS) begin
                if (b >= CH_ZERO && b <= CH_NINE)
                    acc = acc * 16'd10 + 16'(b - CH_ZERO);
                else
                    phase = PH_DONE;
            end
        endfunction

        function void check_value(logic signed [15:0] value, logic [5:0] slot, logic done);
            result_t want;
            if (pending_values.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result: value %0d slot %0d done %0b",
                             value, slot, done);
                return;
            end
            want = pending_values.pop_front();
            if (value !== want.value || slot !== want.slot || done !== want.done) begin
                errors++;
                if (errors <= 10)
                    $display("result mismatch: expected value %0d slot %0d done %0b, %s %0d %0d %0b",
                             want.value, want.slot, want.done, "got", value, slot, done);
            end
        endfunction
    endclass

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      rx_valid = 1'b0;
    logic                      rx_stall;
    logic [7:0]                rx_byte = '0;
    logic                      res_valid;
    logic                      res_stall = 1'b0;
    logic signed [VALUE_W-1:0] field_value;
    logic [SLOT_W-1:0]         slot_index;
    logic                      frame_done;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [1:0]                cfg_index = CFG_START;
    logic [7:0]                cfg_data = '0;

    parsed_value_board sb = new();
    int cycles = 0;
    int stall_left = 0;
    bit rx_steady = 1'b0;
    bit sink_steady = 1'b0;

    framed_csv_integer_parser_top #(
        .MAX_VALUES   (MAX_VALUES),
        .PACKET_BYTES (PACKET_BYTES)
    ) u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .rx_valid    (rx_valid),
        .rx_stall    (rx_stall),
        .rx_byte     (rx_byte),
        .res_valid   (res_valid),
        .res_stall   (res_stall),
        .field_value (field_value),
        .slot_index  (slot_index),
        .frame_done  (frame_done),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && res_valid && !res_stall)
            sb.check_value(field_value, slot_index, frame_done);
    end

    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            res_stall  <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else if (sink_steady)
            res_stall <= 1'b0;
        else
        begin
            case ($urandom_range(0, 19))
                0, 1, 2:
                begin
                    res_stall  <= 1'b1;
                    stall_left <= $urandom_range(0, 2);
                end
                3:
                begin
                    res_stall  <= 1'b1;
                    stall_left <= $urandom_range(8, 40);
                end
                default: res_stall <= 1'b0;
            endcase
        end
    end

    function automatic int pick_gap();
        int roll;
        if (rx_steady)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic push_byte(input logic [7:0] b);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            rx_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        rx_valid <= 1'b1;
        rx_byte  <= b;
        do @(posedge clk); while (rx_stall);
        sb.take_byte(b);
        @(negedge clk);
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [7:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        sb.write_reg(idx, val);
        @(negedge clk);
    endtask

    task automatic wait_idle();
        rx_valid <= 1'b0;
        while (sb.pending_values.size() != 0) @(negedge clk);
        repeat (3) @(negedge clk);
    endtask

    task automatic send_frame();
        int kind;
        int k;
        kind      = $urandom_range(0, 99);
        rx_steady = ($urandom_range(0, 4) == 0);
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 4)) push_byte(8'($urandom));
        push_byte(sb.start_ch);
        if (kind < 65)
        begin
            repeat ($urandom_range(0, 6))
            begin
                repeat ($urandom_range(0, 2))
                    push_byte(($urandom_range(0, 5) == 5) ? CH_SPACE
                                                          : CH_TAB + 8'($urandom_range(0, 4)));
                k = $urandom_range(0, 19);
                if (k < 6)
                    push_byte(CH_MINUS);
                else if (k < 9)
                    push_byte(CH_PLUS);
                if (k == 0)
                    push_byte(CH_PLUS);
                repeat ($urandom_range(0, 6)) push_byte(CH_ZERO + 8'($urandom_range(0, 9)));
                if ($urandom_range(0, 9) == 0)
                    push_byte(8'($urandom));
                push_byte(sb.sep_ch);
            end
            if ($urandom_range(0, 4) == 0)
                repeat ($urandom_range(1, 3)) push_byte(CH_ZERO + 8'($urandom_range(0, 9)));
            push_byte(sb.end_ch);
        end
        else if (kind < 75)
        begin
            repeat ($urandom_range(30, 40))
            begin
                if ($urandom_range(0, 1) == 0)
                    push_byte(CH_ZERO + 8'($urandom_range(0, 9)));
                push_byte(sb.sep_ch);
            end
            push_byte(sb.end_ch);
        end
        else if (kind < 85)
        begin
            repeat ($urandom_range(56, 80))
                push_byte(($urandom_range(0, 4) == 0) ? sb.sep_ch
                                                      : CH_ZERO + 8'($urandom_range(0, 9)));
            push_byte(sb.end_ch);
        end
        else
        begin
            repeat ($urandom_range(1, 20)) push_byte(8'($urandom));
            if ($urandom_range(0, 9) < 7)
                push_byte(sb.end_ch);
        end
    endtask

    initial
    begin
        logic [7:0] warmup [26];
        int target;
        warmup = '{8'hFF, START_CHAR_RST, CH_TAB, CH_CR, CH_SPACE, CH_MINUS,
                   "3", "2", "7", "6", "8", SEP_CHAR_RST, CH_PLUS, CH_PLUS, SEP_CHAR_RST,
                   8'h00, SEP_CHAR_RST, "9", "9", "9", "9", "9", START_CHAR_RST,
                   SEP_CHAR_RST, "7", END_CHAR_RST};
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        foreach (warmup[i])
            push_byte(warmup[i]);
        for (int p = 0; p < 6; p++)
        begin
            if (p > 0)
            begin
                wait_idle();
                sink_steady = (p == 2);
                case (p)
                    1:
                    begin
                        cfg_write(CFG_START, 8'h00);
                        cfg_write(CFG_END, 8'hFF);
                        cfg_write(CFG_SEP, 8'h00);
                    end
                    2:
                    begin
                        cfg_write(CFG_START, 8'hFF);
                        cfg_write(CFG_END, 8'h00);
                        cfg_write(CFG_SEP, 8'hFF);
                    end
                    3:
                    begin
                        cfg_write(CFG_START, "<");
                        cfg_write(CFG_END, 8'd10);
                        cfg_write(CFG_SEP, 8'd10);
                    end
                    4:
                    begin
                        cfg_write(CFG_UNUSED, 8'($urandom));
                        cfg_write(CFG_START, 8'($urandom));
                        cfg_write(CFG_END, 8'($urandom));
                        cfg_write(CFG_SEP, 8'($urandom));
                    end
                    default:
                    begin
                        cfg_write(CFG_START, START_CHAR_RST);
                        cfg_write(CFG_END, END_CHAR_RST);
                        cfg_write(CFG_SEP, SEP_CHAR_RST);
                    end
                endcase
                cfg_valid <= 1'b0;
            end
            target = sb.frame_bytes + 235;
            while (sb.frame_bytes < target)
                send_frame();
        end
        wait_idle();
        if (sb.errors == 0 && sb.pending_values.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

@@ files.f @@
rtl/fcip_pkg.sv
rtl/fcip_field.sv
rtl/fcip_outq.sv
rtl/framed_csv_integer_parser_top.sv
test/tb.sv
